FILE: sv/assert_macros.svh
// Assertion macros shared by the timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Antecedent in one cycle requires the consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/tmhq_pkg.sv
// Shared codes and field widths of the timer min-heap queue.
package tmhq_pkg;
    localparam int ID_W   = 5;
    localparam int TMO_W  = 24;
    localparam int ELA_W  = 16;
    localparam int OP_W   = 3;
    localparam int KIND_W = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd2;
    localparam logic [OP_W-1:0] OP_ADV    = 3'd3;
    localparam logic [OP_W-1:0] OP_NWAIT  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [KIND_W-1:0] EV_EXPIRE = 3'd0;
    localparam logic [KIND_W-1:0] EV_CANCEL = 3'd1;
    localparam logic [KIND_W-1:0] EV_REPORT = 3'd2;
    localparam logic [KIND_W-1:0] EV_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] EV_ABSENT = 3'd4;

    localparam logic [TMO_W-1:0] WAIT_MAX = {TMO_W{1'b1}};
endpackage

FILE: sv/tmhq_mem.sv
// Heap entry memory: one write port, one read port, registered read data.
module tmhq_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 37
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read in the same clocked block; a read returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/timer_min_heap_queue_top.sv
// Timer min-heap queue top level: sequencer, id table, clock and output stage.
// One operation is taken at a time. Add, update and cancel walk the heap one
// level at a time through the heap memory, which has one write port and one
// read port. A next-wait request runs a removal walk for each due timer it
// fires, then reports the wait or that nothing is pending.
// The output register lets a new operation enter while a result waits.
module timer_min_heap_queue_top #(
    parameter int TIMER_SLOTS = 32,
    parameter int TIME_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // timer_id[4:0], timeout_ms[28:5], elapsed_ms[44:29]
    input  logic [2:0]  i_s_tuser,  // operation[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // fired_id[4:0], wait_ms[28:5], nothing_pending[29]
    output logic [2:0]  o_m_tuser,  // event_kind[2:0]
    output logic        o_m_tlast
);
    import tmhq_pkg::*;
    `include "assert_macros.svh"

    localparam int IW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW  = $clog2(TIMER_SLOTS + 1);
    localparam int XW  = IW + 2;
    localparam int TW  = TIME_BITS;
    localparam int EW  = ID_W + TW;
    localparam int NID = 1 << ID_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_LD   = 4'd2;
    localparam logic [3:0] S_DN0  = 4'd3;
    localparam logic [3:0] S_DN1  = 4'd4;
    localparam logic [3:0] S_DN2  = 4'd5;
    localparam logic [3:0] S_DN3  = 4'd6;
    localparam logic [3:0] S_UP0  = 4'd7;
    localparam logic [3:0] S_UP1  = 4'd8;
    localparam logic [3:0] S_WB   = 4'd9;
    localparam logic [3:0] S_NW   = 4'd10;
    localparam logic [3:0] S_NW1  = 4'd11;
    localparam logic [3:0] S_NWRM = 4'd12;
    localparam logic [3:0] S_EMIT = 4'd13;

    logic [3:0]       r_state;
    logic [OP_W-1:0]  r_op;
    logic [ID_W-1:0]  r_id;
    logic [TMO_W-1:0] r_tmo;
    logic [ELA_W-1:0] r_ela;
    logic [TW-1:0]    r_now;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_n;
    logic [NID-1:0]   r_valid;
    logic [IW-1:0]    r_pos [NID];
    logic [ID_W-1:0]  r_cur_id;
    logic [TW-1:0]    r_cur_exp;
    logic [IW-1:0]    r_i;
    logic             r_moved;
    logic [EW-1:0]    r_lch;
    logic [EW-1:0]    r_best;
    logic [IW-1:0]    r_bidx;

    logic [KIND_W-1:0] r_ekind;
    logic [ID_W-1:0]   r_eid;
    logic [TMO_W-1:0]  r_ewait;
    logic              r_enone;
    logic              r_elast;

    logic              r_ovalid;
    logic [31:0]       r_odata;
    logic [2:0]        r_ouser;
    logic              r_olast;

    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic [EW-1:0]  mem_wdata;
    logic [IW-1:0]  mem_raddr;
    logic [EW-1:0]  mem_rdata;

    function automatic logic earlier(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW-1:0] d;
        d = a - b;
        return (d != '0) && d[TW-1];
    endfunction

    tmhq_mem #(.DEPTH(TIMER_SLOTS), .WIDTH(EW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Child and parent positions of the current hole.
    logic [XW-1:0] c_lo;
    logic [XW-1:0] c_hi;
    logic [IW-1:0] parent;
    logic [TW-1:0] rd_exp;
    logic [ID_W-1:0] rd_id;
    logic [TW-1:0] best_exp;
    logic [TW-1:0] delta;
    logic [63:0]   delta_w;
    logic          can_emit;
    logic          id_in_range;
    logic          present;
    logic [IW-1:0] pos_id;
    logic [CW-1:0] cnt_m1;

    assign c_lo     = {1'b0, r_i, 1'b1};
    assign c_hi     = c_lo + XW'(1);
    assign parent   = IW'((r_i - IW'(1)) >> 1);
    assign rd_exp   = mem_rdata[TW-1:0];
    assign rd_id    = mem_rdata[EW-1:TW];
    assign best_exp = r_best[TW-1:0];
    assign delta    = rd_exp - r_now;
    assign delta_w  = 64'(delta);
    assign can_emit = !r_ovalid || i_m_tready;
    assign id_in_range = 32'(r_id) < TIMER_SLOTS;
    assign present  = id_in_range && r_valid[r_id];
    assign pos_id   = r_pos[r_id];
    assign cnt_m1   = r_cnt - CW'(1);

    // Heap memory port control per sequencer step.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = {r_cur_id, r_cur_exp};
        mem_raddr = '0;
        unique case (r_state)
            S_DISP:  mem_raddr = IW'(cnt_m1);
            S_NWRM:  mem_raddr = IW'(cnt_m1);
            S_DN0:   mem_raddr = IW'(c_lo);
            S_DN1:   mem_raddr = IW'(c_hi);
            S_UP0:   mem_raddr = parent;
            S_DN3: begin
                mem_we    = !earlier(r_cur_exp, best_exp);
                mem_wdata = r_best;
            end
            S_UP1: begin
                mem_we    = !earlier(rd_exp, r_cur_exp);
                mem_wdata = mem_rdata;
            end
            S_WB:    mem_we = 1'b1;
            default: mem_raddr = '0;
        endcase
    end

    // Sequencer: dispatch, sift down, sift up, expiry scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_now   <= '0;
            r_valid <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op    <= i_s_tuser;
                        r_id    <= i_s_tdata[4:0];
                        r_tmo   <= i_s_tdata[28:5];
                        r_ela   <= i_s_tdata[44:29];
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_eid     <= (r_op == OP_ADD || r_op == OP_UPDATE || r_op == OP_CANCEL)
                                 ? r_id : '0;
                    r_ewait   <= '0;
                    r_enone   <= 1'b0;
                    r_elast   <= 1'b1;
                    r_moved   <= 1'b0;
                    r_cur_id  <= r_id;
                    r_cur_exp <= r_now + TW'(r_tmo);
                    r_n       <= (r_op == OP_CANCEL) ? cnt_m1 : r_cnt;
                    unique case (r_op)
                        OP_ADD: begin
                            if (!id_in_range) begin
                                r_ekind <= EV_ABSENT;
                                r_state <= S_EMIT;
                            end else if (!present) begin
                                r_ekind        <= EV_DONE;
                                r_i            <= IW'(r_cnt);
                                r_cnt          <= r_cnt + CW'(1);
                                r_valid[r_id]  <= 1'b1;
                                r_state        <= S_UP0;
                            end else begin
                                r_ekind <= EV_DONE;
                                r_i     <= pos_id;
                                r_state <= S_DN0;
                            end
                        end
                        OP_UPDATE: begin
                            if (!present) begin
                                r_ekind <= EV_ABSENT;
                                r_state <= S_EMIT;
                            end else begin
                                r_ekind <= EV_DONE;
                                r_i     <= pos_id;
                                r_state <= S_DN0;
                            end
                        end
                        OP_CANCEL: begin
                            if (!present) begin
                                r_ekind <= EV_ABSENT;
                                r_state <= S_EMIT;
                            end else begin
                                r_ekind       <= EV_CANCEL;
                                r_valid[r_id] <= 1'b0;
                                r_cnt         <= cnt_m1;
                                r_i           <= pos_id;
                                r_state       <= (CW'(pos_id) < cnt_m1) ? S_LD : S_EMIT;
                            end
                        end
                        OP_ADV: begin
                            r_now   <= r_now + TW'(r_ela);
                            r_ekind <= EV_DONE;
                            r_state <= S_EMIT;
                        end
                        OP_NWAIT: begin
                            r_ekind <= EV_DONE;
                            r_state <= S_NW;
                        end
                        OP_CLEAR: begin
                            r_valid <= '0;
                            r_cnt   <= '0;
                            r_ekind <= EV_DONE;
                            r_state <= S_EMIT;
                        end
                        default: begin
                            r_ekind <= EV_DONE;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                // Last entry moves into the hole and sinks from there, or rises if it cannot sink.
                S_LD: begin
                    r_cur_id  <= rd_id;
                    r_cur_exp <= rd_exp;
                    r_moved   <= 1'b0;
                    r_state   <= S_DN0;
                end
                S_DN0: begin
                    if (c_lo >= XW'(r_n)) begin
                        r_state <= r_moved ? S_WB : S_UP0;
                    end else begin
                        r_state <= S_DN1;
                    end
                end
                S_DN1: begin
                    r_lch <= mem_rdata;
                    if (c_hi < XW'(r_n)) begin
                        r_state <= S_DN2;
                    end else begin
                        r_best  <= mem_rdata;
                        r_bidx  <= IW'(c_lo);
                        r_state <= S_DN3;
                    end
                end
                S_DN2: begin
                    if (earlier(rd_exp, r_lch[TW-1:0])) begin
                        r_best <= mem_rdata;
                        r_bidx <= IW'(c_hi);
                    end else begin
                        r_best <= r_lch;
                        r_bidx <= IW'(c_lo);
                    end
                    r_state <= S_DN3;
                end
                S_DN3: begin
                    if (earlier(r_cur_exp, best_exp)) begin
                        r_state <= r_moved ? S_WB : S_UP0;
                    end else begin
                        r_pos[r_best[EW-1:TW]] <= r_i;
                        r_i     <= r_bidx;
                        r_moved <= 1'b1;
                        r_state <= S_DN0;
                    end
                end
                S_UP0: begin
                    r_state <= (r_i == '0) ? S_WB : S_UP1;
                end
                S_UP1: begin
                    if (earlier(rd_exp, r_cur_exp)) begin
                        r_state <= S_WB;
                    end else begin
                        r_pos[rd_id] <= r_i;
                        r_i          <= parent;
                        r_state      <= S_UP0;
                    end
                end
                S_WB: begin
                    r_pos[r_cur_id] <= r_i;
                    r_state <= (r_op == OP_NWAIT) ? S_NW : S_EMIT;
                end
                S_NW: begin
                    r_eid   <= '0;
                    r_ekind <= EV_REPORT;
                    r_ewait <= '0;
                    if (r_cnt == '0) begin
                        r_enone <= 1'b1;
                        r_elast <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_NW1;
                    end
                end
                // Root is due: fire it, otherwise report the wait.
                S_NW1: begin
                    if (delta == '0 || delta[TW-1]) begin
                        r_ekind <= EV_EXPIRE;
                        r_eid   <= rd_id;
                        r_elast <= 1'b0;
                    end else begin
                        r_ewait <= (delta_w > 64'(WAIT_MAX)) ? WAIT_MAX
                                                             : delta_w[TMO_W-1:0];
                        r_elast <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_NWRM: begin
                    r_valid[r_eid] <= 1'b0;
                    r_cnt <= cnt_m1;
                    r_n   <= cnt_m1;
                    r_i   <= '0;
                    r_state <= (cnt_m1 != '0) ? S_LD : S_NW;
                end
                S_EMIT: begin
                    if (can_emit) begin
                        r_state <= r_elast ? S_IDLE : S_NWRM;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register: holds one result beat until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_EMIT && can_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && can_emit) begin
            r_odata <= {2'b00, r_enone, r_ewait, r_eid};
            r_ouser <= r_ekind;
            r_olast <= r_elast;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

    // The pending count always matches the set of valid ids.
    `ASSERT_ALWAYS(a_cnt_matches_valid, i_clk, i_rst_n, $countones(r_valid) == 32'(r_cnt))
    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, 32'(r_cnt) <= TIMER_SLOTS)
    // A fired expiry is always followed by another beat of the same report.
    `ASSERT_NEXT(a_expire_not_last, i_clk, i_rst_n, r_state == S_EMIT && can_emit && r_ekind == EV_EXPIRE, r_state == S_NWRM)
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the timer min-heap queue: directed and random operations.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tmhq_pkg::*;

    localparam int SLOTS = 32;

    // Operation codes the block ignores.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TMO_W-1:0]  wait_ms;
        logic              none;
        logic              last;
    } t_timer_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;
    logic [2:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    timer_min_heap_queue_top u_top (.*);

    always #5 i_clk = ~i_clk;

    // Shadow state of the heap queue.
    logic [ID_W-1:0] hp_id  [SLOTS];
    logic [31:0]     hp_exp [SLOTS];
    int              pos_of [SLOTS];
    bit              armed  [SLOTS];
    int              n_pending;
    logic [31:0]     now_ms;

    t_timer_event events_due[$];
    int  errors = 0;
    int  burst_left = 0;

    function automatic bit is_earlier(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 0 && d[31];
    endfunction

    function automatic void swap_slots(int i, int j);
        logic [ID_W-1:0] t_id;
        logic [31:0]     t_ex;
        t_id = hp_id[i]; t_ex = hp_exp[i];
        hp_id[i] = hp_id[j]; hp_exp[i] = hp_exp[j];
        hp_id[j] = t_id; hp_exp[j] = t_ex;
        pos_of[hp_id[i]] = i;
        pos_of[hp_id[j]] = j;
    endfunction

    function automatic void bubble_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (is_earlier(hp_exp[p], hp_exp[i])) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic bit bubble_down(int start, int n);
        int i, c;
        i = start;
        c = 2 * i + 1;
        while (c < n) begin
            if (c + 1 < n && is_earlier(hp_exp[c+1], hp_exp[c])) c++;
            if (is_earlier(hp_exp[i], hp_exp[c])) break;
            swap_slots(i, c);
            i = c;
            c = 2 * i + 1;
        end
        return i > start;
    endfunction

    function automatic void take_out(int i);
        int n;
        n = n_pending - 1;
        if (i < n) begin
            swap_slots(i, n);
            if (!bubble_down(i, n)) bubble_up(i);
        end
        armed[hp_id[n]] = 1'b0;
        n_pending = n;
    endfunction

    function automatic void push_event(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                       logic [TMO_W-1:0] w, logic none);
        t_timer_event e;
        e = '{kind: k, id: id, wait_ms: w, none: none, last: 1'b0};
        events_due.insert(events_due.size(), e);
    endfunction

    // Predict the events that one operation causes.
    function automatic void predict_events(logic [2:0] op, logic [ID_W-1:0] id,
                                           logic [TMO_W-1:0] tmo, logic [ELA_W-1:0] ela);
        int i;
        logic [31:0] d;
        case (op)
            OP_ADD, OP_UPDATE: begin
                if (!armed[id]) begin
                    if (op == OP_UPDATE) push_event(EV_ABSENT, id, '0, 1'b0);
                    else begin
                        i = n_pending;
                        hp_id[i] = id;
                        hp_exp[i] = now_ms + 32'(tmo);
                        pos_of[id] = i;
                        armed[id] = 1'b1;
                        n_pending = i + 1;
                        bubble_up(i);
                        push_event(EV_DONE, id, '0, 1'b0);
                    end
                end else begin
                    i = pos_of[id];
                    hp_exp[i] = now_ms + 32'(tmo);
                    if (!bubble_down(i, n_pending)) bubble_up(i);
                    push_event(EV_DONE, id, '0, 1'b0);
                end
            end
            OP_CANCEL: begin
                if (!armed[id]) push_event(EV_ABSENT, id, '0, 1'b0);
                else begin
                    push_event(EV_CANCEL, id, '0, 1'b0);
                    take_out(pos_of[id]);
                end
            end
            OP_ADV: begin
                now_ms = now_ms + 32'(ela);
                push_event(EV_DONE, '0, '0, 1'b0);
            end
            OP_NWAIT: begin
                while (n_pending > 0) begin
                    d = hp_exp[0] - now_ms;
                    if (!(d == 0 || d[31])) break;
                    push_event(EV_EXPIRE, hp_id[0], '0, 1'b0);
                    take_out(0);
                end
                if (n_pending == 0) push_event(EV_REPORT, '0, '0, 1'b1);
                else begin
                    d = hp_exp[0] - now_ms;
                    push_event(EV_REPORT, '0, (d > 32'(WAIT_MAX)) ? WAIT_MAX : d[TMO_W-1:0],
                               1'b0);
                end
            end
            OP_CLEAR: begin
                for (int k = 0; k < SLOTS; k++) armed[k] = 1'b0;
                n_pending = 0;
                push_event(EV_DONE, '0, '0, 1'b0);
            end
            default: push_event(EV_DONE, '0, '0, 1'b0);
        endcase
        events_due[events_due.size() - 1].last = 1'b1;
    endfunction

    // Send one operation beat, with bursts and random gaps between them.
    task automatic send_op(logic [2:0] op, logic [ID_W-1:0] id,
                           logic [TMO_W-1:0] tmo, logic [ELA_W-1:0] ela);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {3'b000, ela, tmo, id};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_events(op, id, tmo, ela);
    endtask

    // Receiver stall pattern: long ready stretches alternating with stalls.
    initial begin
        int phase;
        @(posedge i_rst_n);
        forever begin
            phase = $urandom_range(0, 3);
            repeat ($urandom_range(1, 30)) begin
                @(posedge i_clk);
                i_m_tready <= (phase == 0) ? 1'b1 : ($urandom_range(0, phase) != 0);
            end
        end
    end

    // Compare each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_timer_event got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{kind: o_m_tuser, id: o_m_tdata[4:0], wait_ms: o_m_tdata[28:5],
                    none: o_m_tdata[29], last: o_m_tlast};
            if (events_due.size() == 0) begin
                $display("%0t unexpected beat: actual %p", $realtime, got);
                errors++;
            end else begin
                want = events_due.pop_front();
                if (got !== want || o_m_tdata[31:30] !== 2'b00) begin
                    $display("%0t mismatch: expected %p actual %p", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    function automatic logic [TMO_W-1:0] rand_tmo();
        case ($urandom_range(0, 4))
            0: return TMO_W'($urandom_range(0, 20));
            1: return TMO_W'(32'(WAIT_MAX) - $urandom_range(0, 3));
            2: return TMO_W'($urandom_range(0, 2000));
            default: return TMO_W'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        send_op(OP_NWAIT, '0, '0, '0);
        send_op(OP_UPDATE, 5'd5, 24'd7, '0);
        send_op(OP_CANCEL, 5'd31, '0, '0);
        send_op(OP_ADD, '0, '0, '0);
        send_op(OP_ADD, 5'd31, WAIT_MAX, 16'hFFFF);
        send_op(OP_ADD, 5'd3, 24'd100, '0);
        send_op(OP_ADD, 5'd4, 24'd100, '0);
        send_op(OP_ADD, 5'd3, 24'd50, '0);
        send_op(OP_UPDATE, 5'd4, 24'd10, '0);
        send_op(OP_NWAIT, '0, '0, '0);
        send_op(OP_ADV, '0, '0, 16'hFFFF);
        send_op(OP_NWAIT, '0, '0, '0);
        send_op(OP_CANCEL, 5'd31, '0, '0);
        send_op(OP_CANCEL, 5'd31, '0, '0);
        send_op(OP_SPARE_A, 5'd31, WAIT_MAX, 16'hFFFF);
        send_op(OP_SPARE_B, '0, '0, '0);
        send_op(OP_CLEAR, '0, '0, '0);
        send_op(OP_NWAIT, '0, '0, '0);
    endtask

    // Fill every slot with repeated keys of 0, 5 and 10, then let them all expire.
    task automatic test_full_heap();
        for (int k = 0; k < SLOTS; k++) send_op(OP_ADD, ID_W'(k), TMO_W'((k % 3) * 5), '0);
        send_op(OP_ADV, '0, '0, 16'd10);
        send_op(OP_NWAIT, '0, '0, '0);
    endtask

    task automatic test_random(int count);
        logic [2:0] op;
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 35) op = OP_ADD;
            else if (r < 50) op = OP_UPDATE;
            else if (r < 62) op = OP_CANCEL;
            else if (r < 78) op = OP_ADV;
            else if (r < 94) op = OP_NWAIT;
            else if (r < 97) op = OP_CLEAR;
            else op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
            send_op(op, ID_W'($urandom_range(0, 31)), rand_tmo(),
                    ($urandom_range(0, 1) != 0) ? ELA_W'($urandom())
                                                : ELA_W'($urandom_range(0, 300)));
        end
    endtask

    initial begin
        int spin;
        for (int k = 0; k < SLOTS; k++) armed[k] = 1'b0;
        n_pending = 0;
        now_ms = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_heap();
        test_random(420);
        i_s_tvalid <= 1'b0;
        spin = 0;
        while (events_due.size() != 0 && spin < 200000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (100) @(posedge i_clk);
        if (errors == 0 && events_due.size() == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

    // Watchdog.
    initial begin
        #50ms;
        $display("testbench NOT OK");
        $finish;
    end
endmodule

FILE: files.f
+incdir+sv
sv/tmhq_pkg.sv
sv/tmhq_mem.sv
sv/timer_min_heap_queue_top.sv
tb/sv/testbench.sv
